// File: rtl/flrd_pkg.sv
// Shared types and constants of the frequency lookup-table row decoder, used by
// flrd_freq_calc, freq_lut_row_decoder, flrd_entry_checker, tb_top; depends on nothing.
package flrd_pkg;

   localparam int unsigned IDX_W   = 6;
   localparam int unsigned FREQ_W  = 25;
   localparam int unsigned VOLT_W  = 22;
   localparam int unsigned XTAL_W  = 27;
   localparam int unsigned ALT_W   = 32;
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [FREQ_W-1:0] FREQ_MAX = 25'h1FF_FFFF;
   localparam logic [2:0]        TURBO_CORES = 3'd1;
   localparam logic [9:0]        KHZ_DIVISOR = 10'd1000;
   localparam logic [9:0]        MV_TO_UV    = 10'd1000;

   // reciprocals of 125 for exact floor division after a shift by three
   localparam logic [24:0] XTAL_RECIP = 25'd17179870;   // 24-bit operand, shift 31
   localparam logic [29:0] ALT_RECIP  = 30'd549755814;  // 29-bit operand, shift 36
   localparam logic [15:0] LO_RECIP   = 16'd33555;      // 15-bit operand, shift 22

   localparam logic [XTAL_W-1:0] XTAL_RESET = 27'd19200000;
   localparam logic [ALT_W-1:0]  ALT_RESET  = 32'd300000000;

   localparam logic [CSR_IDX_W-1:0] CSR_CRYSTAL_RATE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALTERNATE_RATE = 1'd1;

   typedef enum logic [2:0] {
      KIND_FREQ    = 3'd0,
      KIND_INVALID = 3'd1,
      KIND_BLANK   = 3'd2,
      KIND_BOOST   = 3'd3,
      KIND_END     = 3'd4
   } entry_kind_type;

   typedef struct packed {
      logic [FREQ_W-1:0] khz;
      logic [VOLT_W-1:0] volt_uv;
      logic              turbo;
   } row_type;

   typedef struct packed {
      logic [IDX_W-1:0]  entry_index;
      entry_kind_type    entry_kind;
      logic [FREQ_W-1:0] khz;
      logic [VOLT_W-1:0] volt_uv;
      logic              last;
   } result_type;

endpackage

// File: rtl/flrd_freq_calc.sv
// Five-stage pipeline that turns a raw table row into frequency in kHz and
// voltage in uV. Depends on flrd_pkg.
module flrd_freq_calc (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [flrd_pkg::WORD_W-1:0]   freq_row_word,
   input  logic [flrd_pkg::WORD_W-1:0]   volt_row_word,
   input  logic [flrd_pkg::XTAL_W-1:0]   crystal_rate_hz,
   input  logic [flrd_pkg::ALT_W-1:0]    alternate_rate_hz,
   output logic                          out_valid,
   input  logic                          out_ready,
   output flrd_pkg::row_type             out_row
);

   logic [5:1] valid_ff, valid_in, ready;

   logic        s1_src_ff, s1_turbo_ff;
   logic [7:0]  s1_mult_ff;
   logic [11:0] s1_vcode_ff;
   logic [26:0] s1_crystal_ff;
   logic [31:0] s1_alt_ff;

   logic        s2_src_ff, s2_turbo_ff;
   logic [7:0]  s2_mult_ff;
   logic [17:0] s2_q_ff;
   logic [26:0] s2_crystal_ff;
   logic [22:0] s2_alt_q_ff;
   logic [21:0] s2_volt_ff;
   logic [48:0] s2_q_prod;
   logic [58:0] s2_alt_prod;

   logic        s3_src_ff, s3_turbo_ff;
   logic [7:0]  s3_mult_ff;
   logic [9:0]  s3_rem_ff;
   logic [25:0] s3_hi_ff;
   logic [22:0] s3_alt_q_ff;
   logic [21:0] s3_volt_ff;
   logic [26:0] s3_rem_full;

   logic        s4_src_ff, s4_turbo_ff;
   logic [17:0] s4_prod_ff;
   logic [25:0] s4_hi_ff;
   logic [22:0] s4_alt_q_ff;
   logic [21:0] s4_volt_ff;

   flrd_pkg::row_type s5_row_ff, s5_row_in;
   logic [30:0] s5_lo_prod;
   logic [26:0] s5_sum;

   // advance a stage when it is empty or its successor advances
   always_comb begin
      ready[5] = !valid_ff[5] || out_ready;
      for (int k = 4; k >= 1; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      valid_in[1] = ready[1] ? in_valid : valid_ff[1];
      for (int k = 2; k <= 5; k++) begin
         valid_in[k] = ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign s2_q_prod   = 49'(s1_crystal_ff[26:3]) * 49'(flrd_pkg::XTAL_RECIP);
   assign s2_alt_prod = 59'(s1_alt_ff[31:3]) * 59'(flrd_pkg::ALT_RECIP);
   assign s3_rem_full = s2_crystal_ff - 27'(27'(s2_q_ff) * 27'(flrd_pkg::KHZ_DIVISOR));
   assign s5_lo_prod  = 31'(s4_prod_ff[17:3]) * 31'(flrd_pkg::LO_RECIP);
   assign s5_sum      = 27'(s4_hi_ff) + 27'(s5_lo_prod[30:22]);

   always_comb begin
      s5_row_in.volt_uv = s4_volt_ff;
      s5_row_in.turbo   = s4_turbo_ff;
      if (!s4_src_ff) begin
         s5_row_in.khz = 25'(s4_alt_q_ff);
      end else if (s5_sum > 27'(flrd_pkg::FREQ_MAX)) begin
         s5_row_in.khz = flrd_pkg::FREQ_MAX;
      end else begin
         s5_row_in.khz = s5_sum[24:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ready[1]) begin
         s1_src_ff     <= freq_row_word[31:30] != 2'd0;
         s1_turbo_ff   <= freq_row_word[18:16] == flrd_pkg::TURBO_CORES;
         s1_mult_ff    <= freq_row_word[7:0];
         s1_vcode_ff   <= volt_row_word[11:0];
         s1_crystal_ff <= crystal_rate_hz;
         s1_alt_ff     <= alternate_rate_hz;
      end
      if (ready[2]) begin
         s2_src_ff     <= s1_src_ff;
         s2_turbo_ff   <= s1_turbo_ff;
         s2_mult_ff    <= s1_mult_ff;
         s2_q_ff       <= s2_q_prod[48:31];
         s2_crystal_ff <= s1_crystal_ff;
         s2_alt_q_ff   <= s2_alt_prod[58:36];
         s2_volt_ff    <= 22'(s1_vcode_ff) * 22'(flrd_pkg::MV_TO_UV);
      end
      if (ready[3]) begin
         s3_src_ff   <= s2_src_ff;
         s3_turbo_ff <= s2_turbo_ff;
         s3_mult_ff  <= s2_mult_ff;
         s3_rem_ff   <= s3_rem_full[9:0];
         s3_hi_ff    <= 26'(s2_mult_ff) * 26'(s2_q_ff);
         s3_alt_q_ff <= s2_alt_q_ff;
         s3_volt_ff  <= s2_volt_ff;
      end
      if (ready[4]) begin
         s4_src_ff   <= s3_src_ff;
         s4_turbo_ff <= s3_turbo_ff;
         s4_prod_ff  <= 18'(s3_mult_ff) * 18'(s3_rem_ff);
         s4_hi_ff    <= s3_hi_ff;
         s4_alt_q_ff <= s3_alt_q_ff;
         s4_volt_ff  <= s3_volt_ff;
      end
      if (ready[5]) begin
         s5_row_ff <= s5_row_in;
      end
   end

   assign in_ready  = ready[1];
   assign out_valid = valid_ff[5];
   assign out_row   = s5_row_ff;

endmodule

// File: rtl/freq_lut_row_decoder.sv
// Top level of the frequency lookup-table row decoder: configuration
// registers, table state, entry decision and result buffer.
// Depends on flrd_pkg and flrd_freq_calc.
//
//   channel  direction  payload                                    handshake
//   req_     in         tdata: freq_row_word, volt_row_word         tvalid/tready
//   rsp_     out        tdata: index, kind, freq, volt; tlast       tvalid/tready
//   csr_     in         index, wdata                                valid/ready
//
// One row is taken per cycle while results drain and no row yields two entries;
// such a row holds the decision stage until its first entry has been sent.
// Synchronous reset clears pipeline and table state and presets the rate registers.
// A stalled result side fills the pipeline, then drops req_tready.
module freq_lut_row_decoder #(
   parameter int unsigned TABLE_ROWS = 40
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] freq_row_word, [63:32] volt_row_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [5:0] entry_index, [8:6] entry_kind,
                                    // [33:9] frequency kHz, [55:34] volt_uv
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [flrd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0] csr_wdata
);

   logic [flrd_pkg::XTAL_W-1:0] crystal_ff;
   logic [flrd_pkg::ALT_W-1:0]  alternate_ff;

   logic                        row_valid, take;
   flrd_pkg::row_type           row;

   logic [flrd_pkg::IDX_W-1:0]  row_count_ff, row_count_in;
   logic [flrd_pkg::FREQ_W-1:0] last_khz_ff, last_khz_in;
   logic                        prev_inv_ff, prev_inv_in;

   flrd_pkg::result_type        first, second;
   logic                        two;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        pend_valid_ff, pend_valid_in;
   flrd_pkg::result_type        rsp_ff, rsp_in, pend_ff, pend_in;

   logic [flrd_pkg::IDX_W-1:0]  next_count;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         crystal_ff   <= flrd_pkg::XTAL_RESET;
         alternate_ff <= flrd_pkg::ALT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            flrd_pkg::CSR_CRYSTAL_RATE:   crystal_ff   <= csr_wdata[26:0];
            flrd_pkg::CSR_ALTERNATE_RATE: alternate_ff <= csr_wdata;
         endcase
      end
   end

   flrd_freq_calc u_calc (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (req_tvalid),
      .in_ready          (req_tready),
      .freq_row_word     (req_tdata[31:0]),
      .volt_row_word     (req_tdata[63:32]),
      .crystal_rate_hz   (crystal_ff),
      .alternate_rate_hz (alternate_ff),
      .out_valid         (row_valid),
      .out_ready         (take),
      .out_row           (row)
   );

   // take a row only when both result slots can hold what it yields
   assign take = row_valid && !pend_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign next_count = row_count_ff + 6'd1;

   always_comb begin
      first        = '0;
      second       = '0;
      two          = 1'b0;
      row_count_in = next_count;
      last_khz_in  = row.khz;
      prev_inv_in  = row.turbo;
      first.entry_index = row_count_ff;
      first.volt_uv     = row.volt_uv;
      if (row_count_ff != '0 && row.khz == last_khz_ff) begin
         row_count_in = '0;
         last_khz_in  = '0;
         prev_inv_in  = 1'b0;
         second.entry_index = row_count_ff;
         second.entry_kind  = flrd_pkg::KIND_END;
         second.last        = 1'b1;
         if (prev_inv_ff) begin
            two = 1'b1;
            first.entry_index = row_count_ff - 6'd1;
            first.entry_kind  = flrd_pkg::KIND_BOOST;
            first.khz         = last_khz_ff;
         end else begin
            first = second;
         end
      end else begin
         if (row.khz != last_khz_ff && !row.turbo) begin
            first.entry_kind = flrd_pkg::KIND_FREQ;
            first.khz        = row.khz;
         end else if (row.turbo) begin
            first.entry_kind = flrd_pkg::KIND_INVALID;
         end else begin
            first.entry_kind = flrd_pkg::KIND_BLANK;
         end
         if (next_count == 6'(TABLE_ROWS)) begin
            two = 1'b1;
            second.entry_index = 6'(TABLE_ROWS);
            second.entry_kind  = flrd_pkg::KIND_END;
            second.last        = 1'b1;
            row_count_in = '0;
            last_khz_in  = '0;
            prev_inv_in  = 1'b0;
         end else begin
            first.last = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      pend_valid_in = pend_valid_ff;
      rsp_in        = rsp_ff;
      pend_in       = pend_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in  = pend_valid_ff;
         rsp_in        = pend_ff;
         pend_valid_in = 1'b0;
      end
      if (take) begin
         rsp_valid_in  = 1'b1;
         rsp_in        = first;
         pend_valid_in = two;
         pend_in       = second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff  <= '0;
         last_khz_ff   <= '0;
         prev_inv_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            row_count_ff <= row_count_in;
            last_khz_ff  <= last_khz_in;
            prev_inv_ff  <= prev_inv_in;
         end
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      pend_ff <= pend_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.volt_uv, rsp_ff.khz, rsp_ff.entry_kind,
                        rsp_ff.entry_index};
   assign rsp_tlast  = rsp_ff.last;

endmodule

// File: verif/flrd_entry_checker.sv
`timescale 1ns / 1ps
// Result checker for freq_lut_row_decoder: follows the row, result and register
// channels, decodes every accepted row into its table entries and compares them.
// Depends on flrd_pkg.
module flrd_entry_checker #(
   parameter int unsigned TABLE_ROWS = 40
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [63:0]                    req_tdata,   // [31:0] freq_row_word,
                                                       // [63:32] volt_row_word
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [55:0]                    rsp_tdata,   // [5:0] entry_index, [8:6] entry_kind,
                                                       // [33:9] frequency kHz, [55:34] volt_uv
   input  logic                           rsp_tlast,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [flrd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_wdata,
   output int                             fail_count,
   output int                             pending
);

   typedef logic [flrd_pkg::IDX_W-1:0]  index_type;
   typedef logic [flrd_pkg::FREQ_W-1:0] freq_type;
   typedef logic [flrd_pkg::VOLT_W-1:0] volt_type;

   typedef struct {
      index_type                index;
      flrd_pkg::entry_kind_type kind;
      freq_type                 freq;
      volt_type                 volt;
      logic                     last;
   } table_entry_type;

   table_entry_type                entries_due[$];
   logic [flrd_pkg::XTAL_W-1:0]    xtal_rate;
   logic [flrd_pkg::ALT_W-1:0]     alt_rate;
   index_type                      row_cnt;
   freq_type                       last_khz;
   logic                           prev_turbo;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: %s: got %0d, wanted %0d", $time, what, got, want);
      fail_count++;
   endtask

   task automatic add_entry(input index_type idx, input flrd_pkg::entry_kind_type kind,
                            input freq_type freq, input volt_type volt,
                            input logic last);
      table_entry_type e;
      e.index = idx;
      e.kind  = kind;
      e.freq  = freq;
      e.volt  = volt;
      e.last  = last;
      entries_due.push_back(e);
   endtask

   task automatic clear_table();
      row_cnt    = '0;
      last_khz   = '0;
      prev_turbo = 1'b0;
   endtask

   task automatic decode_row(input logic [flrd_pkg::WORD_W-1:0] fw,
                             input logic [flrd_pkg::WORD_W-1:0] vw);
      logic [1:0]               src;
      logic [2:0]               cores;
      logic [7:0]               mult;
      volt_type                 volt;
      logic [63:0]              wide;
      freq_type                 freq;
      index_type                pos;
      flrd_pkg::entry_kind_type kind;
      src   = fw[31:30];
      cores = fw[18:16];
      mult  = fw[7:0];
      volt  = volt_type'(vw[11:0]) * volt_type'(flrd_pkg::MV_TO_UV);
      pos   = (row_cnt >= TABLE_ROWS) ? index_type'(TABLE_ROWS - 1) : row_cnt;
      if (src != 2'd0)
         wide = 64'(xtal_rate) * 64'(mult) / 64'(flrd_pkg::KHZ_DIVISOR);
      else
         wide = 64'(alt_rate) / 64'(flrd_pkg::KHZ_DIVISOR);
      freq = (wide > 64'(flrd_pkg::FREQ_MAX)) ? flrd_pkg::FREQ_MAX
                                             : wide[flrd_pkg::FREQ_W-1:0];

      // a repeated frequency closes the table, promoting a pending turbo entry
      if (pos != '0 && freq == last_khz) begin
         if (prev_turbo)
            add_entry(pos - 1'b1, flrd_pkg::KIND_BOOST, last_khz, volt, 1'b0);
         add_entry(pos, flrd_pkg::KIND_END, '0, '0, 1'b1);
         clear_table();
      end else begin
         if (cores == flrd_pkg::TURBO_CORES)
            kind = flrd_pkg::KIND_INVALID;
         else if (freq != last_khz)
            kind = flrd_pkg::KIND_FREQ;
         else
            kind = flrd_pkg::KIND_BLANK;
         add_entry(pos, kind, (kind == flrd_pkg::KIND_FREQ) ? freq : '0, volt,
                   (int'(pos) + 1 < TABLE_ROWS));
         prev_turbo = (kind == flrd_pkg::KIND_INVALID);
         last_khz   = freq;
         row_cnt    = pos + 1'b1;
         if (row_cnt >= TABLE_ROWS) begin
            add_entry(index_type'(TABLE_ROWS), flrd_pkg::KIND_END, '0, '0, 1'b1);
            clear_table();
         end
      end
   endtask

   always @(posedge clock) begin : watch
      table_entry_type got;
      table_entry_type want;
      if (reset) begin
         entries_due.delete();
         xtal_rate = flrd_pkg::XTAL_RESET;
         alt_rate  = flrd_pkg::ALT_RESET;
         clear_table();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.index = rsp_tdata[5:0];
            got.kind  = flrd_pkg::entry_kind_type'(rsp_tdata[8:6]);
            got.freq  = rsp_tdata[33:9];
            got.volt  = rsp_tdata[55:34];
            got.last  = rsp_tlast;
            if (entries_due.size() == 0) begin
               report_mismatch("entry transfer with none outstanding, index",
                               got.index, '0);
            end else begin
               want = entries_due.pop_front();
               if (got.index != want.index)
                  report_mismatch("entry_index", got.index, want.index);
               if (got.kind != want.kind)
                  report_mismatch("entry_kind", got.kind, want.kind);
               if (got.freq != want.freq)
                  report_mismatch("frequency kHz", got.freq, want.freq);
               if (got.volt != want.volt)
                  report_mismatch("volt_uv", got.volt, want.volt);
               if (got.last != want.last)
                  report_mismatch("tlast", got.last, want.last);
            end
         end
         if (req_tvalid && req_tready)
            decode_row(req_tdata[31:0], req_tdata[63:32]);
         if (csr_valid && csr_ready) begin
            if (csr_index == flrd_pkg::CSR_CRYSTAL_RATE)
               xtal_rate = csr_wdata[flrd_pkg::XTAL_W-1:0];
            else if (csr_index == flrd_pkg::CSR_ALTERNATE_RATE)
               alt_rate = csr_wdata;
         end
      end
      pending = entries_due.size();
   end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for freq_lut_row_decoder: clock, reset, row and register
// stimulus, result back-pressure, watchdog and verdict.
// Depends on flrd_pkg, freq_lut_row_decoder and flrd_entry_checker.
module tb_top;

   localparam int unsigned TABLE_ROWS = 40;
   localparam int          SETTLE     = 10;
   localparam int          LONG_HOLD  = 400;
   localparam int          IDLE_LIMIT = 3000;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [63:0]                    req_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [55:0]                    rsp_tdata;
   logic                           rsp_tlast;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [flrd_pkg::CSR_IDX_W-1:0] csr_index;
   logic [31:0]                    csr_wdata;

   int fail_count;
   int pending;
   int rows_sent;
   int idle_cycles;
   bit tx_calm;
   bit rx_calm;

   freq_lut_row_decoder #(.TABLE_ROWS(TABLE_ROWS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   flrd_entry_checker #(.TABLE_ROWS(TABLE_ROWS)) entry_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[freq_lut_row_decoder] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side: random hold-offs, calm stretches and two long stalls
   initial begin : receiver
      int gap;
      int taken;
      rsp_tready = 1'b0;
      rx_calm    = 1'b0;
      taken      = 0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (taken % 50 == 0)
            rx_calm = ($urandom_range(0, 3) == 0);
         gap = rx_calm ? 0 : $urandom_range(0, 13);
         if (taken == 250 || taken == 900)
            gap = LONG_HOLD;
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         taken++;
      end
   end

   function automatic logic [flrd_pkg::WORD_W-1:0] freq_word(input logic [1:0] src,
                                                             input logic [2:0] cores,
                                                             input logic [7:0] mult);
      logic [flrd_pkg::WORD_W-1:0] w;
      w        = $urandom;
      w[31:30] = src;
      w[18:16] = cores;
      w[7:0]   = mult;
      return w;
   endfunction

   task automatic send_row(input logic [flrd_pkg::WORD_W-1:0] fw,
                           input logic [flrd_pkg::WORD_W-1:0] vw);
      int gap;
      if (rows_sent % 64 == 0)
         tx_calm = ($urandom_range(0, 3) == 0);
      gap = tx_calm ? 0 : $urandom_range(0, 13);
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {vw, fw};
      do @(posedge clock); while (!(req_tvalid && req_tready));
      rows_sent++;
   endtask

   // drop the row channel and hold until every entry has come back
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_csr(input logic [flrd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
   endtask

   task automatic configure(input logic [flrd_pkg::XTAL_W-1:0] xtal,
                            input logic [flrd_pkg::ALT_W-1:0] alt);
      wait_drained();
      write_csr(flrd_pkg::CSR_CRYSTAL_RATE, 32'(xtal));
      write_csr(flrd_pkg::CSR_ALTERNATE_RATE, alt);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // a table of distinct multipliers with scattered turbo rows, closed by a repeat
   task automatic send_table();
      int                          rows;
      logic [7:0]                  base;
      logic [flrd_pkg::WORD_W-1:0] fw;
      logic [flrd_pkg::WORD_W-1:0] last_fw;
      rows    = ($urandom_range(0, 3) == 0) ? $urandom_range(38, 44) : $urandom_range(1, 12);
      base    = $urandom;
      last_fw = '0;
      for (int j = 0; j < rows; j++) begin
         fw = freq_word(($urandom_range(0, 19) == 0) ? 2'd0 : 2'($urandom_range(1, 3)),
                        ($urandom_range(0, 4) == 0) ? flrd_pkg::TURBO_CORES : 3'($urandom),
                        base + 8'(j));
         send_row(fw, $urandom);
         last_fw = fw;
      end
      fw = freq_word((last_fw[31:30] == 2'd0) ? 2'd0 : 2'($urandom_range(1, 3)),
                     ($urandom_range(0, 1) == 0) ? flrd_pkg::TURBO_CORES : 3'($urandom),
                     last_fw[7:0]);
      send_row(fw, $urandom);
   endtask

   task automatic random_rows(input int count);
      int target;
      target = rows_sent + count;
      while (rows_sent < target) begin
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 5)) send_row($urandom, $urandom);
         else
            send_table();
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      rows_sent   = 0;
      idle_cycles = 0;
      tx_calm     = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      configure(flrd_pkg::XTAL_RESET, flrd_pkg::ALT_RESET);
      // blank first row, then a zero repeat closes the table
      send_row(freq_word(2'd1, 3'd0, 8'd0), 32'h0000_0000);
      send_row(freq_word(2'd1, 3'd2, 8'd0), $urandom);
      // all-ones words, turbo row, boost on the closing repeat
      send_row(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_row(freq_word(2'd1, flrd_pkg::TURBO_CORES, 8'd100), $urandom);
      send_row(freq_word(2'd2, 3'd5, 8'd100), 32'h0000_0FFF);
      // alternate source with turbo on the closing row too
      send_row(freq_word(2'd0, flrd_pkg::TURBO_CORES, 8'd7), $urandom);
      send_row(freq_word(2'd0, flrd_pkg::TURBO_CORES, 8'd9), $urandom);
      // zero frequency turbo on the first row is invalid, not blank
      send_row(freq_word(2'd1, flrd_pkg::TURBO_CORES, 8'd0), $urandom);
      send_row(freq_word(2'd1, 3'd0, 8'd0), $urandom);
      send_row(32'h0000_0000, 32'h0000_0000);
      send_row(freq_word(2'd3, flrd_pkg::TURBO_CORES, 8'd255), 32'hFFFF_FFFF);
      send_row(32'hFFFF_FFFF, $urandom);
      send_row(freq_word(2'd0, 3'd7, 8'd255), 32'hFFFF_F000);
      send_row(freq_word(2'd1, 3'd3, 8'd1), $urandom);
      send_row(freq_word(2'd1, 3'd3, 8'd1), $urandom);
      random_rows(380);

      configure('0, '0);
      random_rows(150);

      configure(27'd100000000, 32'hFFFF_FFFF);
      random_rows(300);

      // crystal rate high enough to saturate the frequency
      configure('1, 32'd999);
      send_row(freq_word(2'd1, 3'd0, 8'd255), $urandom);
      send_row(freq_word(2'd3, flrd_pkg::TURBO_CORES, 8'd254), $urandom);
      send_row(freq_word(2'd2, 3'd0, 8'd253), $urandom);
      random_rows(150);

      configure(27'($urandom_range(1000, 100000000)), $urandom);
      random_rows(300);

      wait_drained();
      if (fail_count == 0)
         $display("[freq_lut_row_decoder] OK");
      else
         $display("[freq_lut_row_decoder] ERROR");
      $finish;
   end

endmodule

// File: sim.f
rtl/flrd_pkg.sv
rtl/flrd_freq_calc.sv
rtl/freq_lut_row_decoder.sv
verif/flrd_entry_checker.sv
verif/tb_top.sv
